@@ rtl/core/vbls_pkg.sv @@
// ----------------------------------------------------------------------------
// vbls_pkg
// shared constants, codes and types for the bundle list scheduler
// ----------------------------------------------------------------------------
package vbls_pkg;

	// default sizes
	localparam int unsigned DEF_SLOT_COUNT   = 1024;
	localparam int unsigned DEF_MAX_BUNDLES  = 4096;
	localparam int unsigned DEF_ENGINE_COUNT = 5;

	// field widths
	localparam int unsigned SLOT_FIELD_W   = 11;
	localparam int unsigned ENGINE_FIELD_W = 3;
	localparam int unsigned BUNDLE_W       = 12;
	localparam int unsigned COUNT_W        = 13;
	localparam int unsigned LIMIT_W        = 4;
	localparam int unsigned MAX_ENGINES    = 8;

	// configuration port
	localparam int unsigned CFG_COUNT = 5;
	localparam int unsigned PADDR_W   = 5;
	localparam int unsigned PDATA_W   = 32;

	// action codes
	localparam logic ACT_SCHEDULE = 1'b0;
	localparam logic ACT_RESTART  = 1'b1;

	// issue slot limits after reset; engines past the register file stay at one
	localparam logic [LIMIT_W-1:0] RESET_LIMITS [MAX_ENGINES] = '{
		4'd12, 4'd6, 4'd2, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1
	};

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_RD_D,
		ST_EARLY,
		ST_SCAN,
		ST_COMMIT
	} vbls_state_t;

endpackage

@@ rtl/core/vbls_ram.sv @@
// ----------------------------------------------------------------------------
// vbls_ram
// simple dual port synchronous ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module vbls_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned WIDTH = 13,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/vbls_cfg.sv @@
// ----------------------------------------------------------------------------
// vbls_cfg
// apb register file holding the per-engine issue slot limits
// ----------------------------------------------------------------------------
module vbls_cfg #(
	parameter int unsigned ENGINE_COUNT = vbls_pkg::DEF_ENGINE_COUNT
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                psel,
	input  logic                                                penable,
	input  logic                                                pwrite,
	input  logic [vbls_pkg::PADDR_W-1:0]                        paddr,
	input  logic [vbls_pkg::PDATA_W-1:0]                        pwdata,
	output logic [vbls_pkg::PDATA_W-1:0]                        prdata,
	output logic                                                pready,
	output logic [ENGINE_COUNT-1:0][vbls_pkg::LIMIT_W-1:0]      limits
);
	import vbls_pkg::*;

	localparam int unsigned IDX_W = PADDR_W - 2;

	logic [LIMIT_W-1:0] lim_q [CFG_COUNT];
	logic [IDX_W-1:0]   reg_idx;
	logic               idx_ok;
	logic               wr_en;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign idx_ok  = 32'(reg_idx) < CFG_COUNT;
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_COUNT; i++) begin
				lim_q[i] <= RESET_LIMITS[i];
			end
		end else if (wr_en && idx_ok) begin
			lim_q[reg_idx] <= pwdata[LIMIT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (idx_ok) begin
			prdata = PDATA_W'(lim_q[reg_idx]);
		end
	end

	for (genvar e = 0; e < ENGINE_COUNT; e++) begin : g_lim
		if (e < CFG_COUNT) begin : g_reg
			assign limits[e] = lim_q[e];
		end else begin : g_fixed
			assign limits[e] = RESET_LIMITS[e];
		end
	end

endmodule

@@ rtl/core/vbls_ctrl.sv @@
// ----------------------------------------------------------------------------
// vbls_ctrl
// sequencer: clears both rams, reads last writers, scans bundle usage, commits and emits
// ----------------------------------------------------------------------------
module vbls_ctrl #(
	parameter int unsigned SLOT_COUNT   = vbls_pkg::DEF_SLOT_COUNT,
	parameter int unsigned MAX_BUNDLES  = vbls_pkg::DEF_MAX_BUNDLES,
	parameter int unsigned ENGINE_COUNT = vbls_pkg::DEF_ENGINE_COUNT,
	localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
	localparam int unsigned BW = (MAX_BUNDLES > 1) ? $clog2(MAX_BUNDLES) : 1,
	localparam int unsigned RW = ENGINE_COUNT * vbls_pkg::LIMIT_W
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           op_valid,
	output logic                                           op_stall,
	input  logic                                           action,
	input  logic [vbls_pkg::ENGINE_FIELD_W-1:0]            engine,
	input  logic signed [vbls_pkg::SLOT_FIELD_W-1:0]       dest_slot,
	input  logic signed [vbls_pkg::SLOT_FIELD_W-1:0]       src_a_slot,
	input  logic signed [vbls_pkg::SLOT_FIELD_W-1:0]       src_b_slot,
	output logic                                           res_valid,
	input  logic                                           res_stall,
	output logic [vbls_pkg::BUNDLE_W-1:0]                  bundle,
	output logic [vbls_pkg::COUNT_W-1:0]                   bundle_count,
	output logic                                           overflow,
	input  logic [ENGINE_COUNT-1:0][vbls_pkg::LIMIT_W-1:0] limits,
	output logic                                           lw_we,
	output logic [SW-1:0]                                  lw_waddr,
	output logic [BW:0]                                    lw_wdata,
	output logic [SW-1:0]                                  lw_raddr,
	input  logic [BW:0]                                    lw_rdata,
	output logic                                           use_we,
	output logic [BW-1:0]                                  use_waddr,
	output logic [RW-1:0]                                  use_wdata,
	output logic [BW-1:0]                                  use_raddr,
	input  logic [RW-1:0]                                  use_rdata
);
	import vbls_pkg::*;

	localparam int unsigned CW = BW + 1;
	localparam int unsigned EW = (ENGINE_COUNT > 1) ? $clog2(ENGINE_COUNT) : 1;
	localparam int unsigned CLR_DEPTH = (SLOT_COUNT > MAX_BUNDLES) ? SLOT_COUNT : MAX_BUNDLES;
	localparam int unsigned CLRW = $clog2(CLR_DEPTH);

	typedef logic [ENGINE_COUNT-1:0][LIMIT_W-1:0] row_t;

	vbls_state_t state_q, state_d;

	logic [CLRW-1:0]   clr_q;
	logic              restart_q;
	logic [EW-1:0]     eng_q;
	logic              d_v_q, a_v_q, b_v_q;
	logic [SW-1:0]     d_q, a_q, b_q;
	logic              a_w_q, b_w_q, d_w_q;
	logic [BW-1:0]     a_wb_q, b_wb_q, d_wb_q;
	logic [CW-1:0]     earliest_q;
	logic [CW-1:0]     scan_q;
	logic              chk_v_s1;
	logic [CW-1:0]     chk_nb_s1;
	logic [CW-1:0]     place_q;
	row_t              row_q;
	logic              ovf_q;
	logic [CW-1:0]     bu_q;
	logic              res_valid_q;
	logic [BW-1:0]     res_bundle_q;
	logic [CW-1:0]     res_count_q;
	logic              res_ovf_q;

	logic              d_ok, a_ok, b_ok;
	logic [EW-1:0]     eng_c;
	row_t              use_row;
	row_t              row_inc;
	row_t              row_new;
	logic              hit;
	logic              more;
	logic              commit_go;
	logic [CW-1:0]     ea, eb;
	logic [CW-1:0]     new_place;
	logic [CW-1:0]     bu_next;

	// slot decode: sign bit or out of range means none
	assign d_ok = !dest_slot[SLOT_FIELD_W-1] && (32'(dest_slot[SLOT_FIELD_W-2:0]) < SLOT_COUNT);
	assign a_ok = !src_a_slot[SLOT_FIELD_W-1] && (32'(src_a_slot[SLOT_FIELD_W-2:0]) < SLOT_COUNT);
	assign b_ok = !src_b_slot[SLOT_FIELD_W-1] && (32'(src_b_slot[SLOT_FIELD_W-2:0]) < SLOT_COUNT);
	assign eng_c = (32'(engine) >= ENGINE_COUNT) ? EW'(ENGINE_COUNT - 1) : EW'(engine);

	assign use_row = row_t'(use_rdata);

	always_comb begin
		row_inc = use_row;
		row_inc[eng_q] = use_row[eng_q] + LIMIT_W'(1);
		row_new = '0;
		row_new[eng_q] = LIMIT_W'(1);
	end

	assign hit = (use_row[eng_q] < limits[eng_q])
		&& !(d_w_q && (CW'(d_wb_q) == chk_nb_s1))
		&& !(a_w_q && (CW'(a_wb_q) == chk_nb_s1))
		&& !(b_w_q && (CW'(b_wb_q) == chk_nb_s1));
	assign more = scan_q < bu_q;
	assign commit_go = !res_valid_q || !res_stall;

	assign ea = a_w_q ? (CW'(a_wb_q) + CW'(1)) : '0;
	assign eb = b_w_q ? (CW'(b_wb_q) + CW'(1)) : '0;
	assign new_place = (bu_q > earliest_q) ? bu_q : earliest_q;
	assign bu_next = (place_q >= bu_q) ? (place_q + CW'(1)) : bu_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (32'(clr_q) == CLR_DEPTH - 1) begin
					state_d = restart_q ? ST_COMMIT : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (op_valid) begin
					state_d = (action == ACT_RESTART) ? ST_CLEAR : ST_RD_A;
				end
			end
			ST_RD_A:  state_d = ST_RD_B;
			ST_RD_B:  state_d = ST_RD_D;
			ST_RD_D:  state_d = ST_EARLY;
			ST_EARLY: state_d = ST_SCAN;
			ST_SCAN: begin
				if ((chk_v_s1 && hit) || (!chk_v_s1 && !more)) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (commit_go) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	// memory ports and handshake
	always_comb begin
		op_stall  = 1'b1;
		lw_we     = 1'b0;
		lw_waddr  = d_q;
		lw_wdata  = {1'b1, place_q[BW-1:0]};
		lw_raddr  = d_q;
		use_we    = 1'b0;
		use_waddr = place_q[BW-1:0];
		use_wdata = RW'(row_q);
		use_raddr = scan_q[BW-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				lw_we     = 32'(clr_q) < SLOT_COUNT;
				lw_waddr  = clr_q[SW-1:0];
				lw_wdata  = '0;
				use_we    = 32'(clr_q) < MAX_BUNDLES;
				use_waddr = clr_q[BW-1:0];
				use_wdata = '0;
			end
			ST_IDLE:  op_stall = 1'b0;
			ST_RD_A:  lw_raddr = a_q;
			ST_RD_B:  lw_raddr = b_q;
			ST_RD_D:  lw_raddr = d_q;
			ST_EARLY: lw_raddr = d_q;
			ST_SCAN:  lw_raddr = d_q;
			ST_COMMIT: begin
				use_we = commit_go && !restart_q && !ovf_q;
				lw_we  = commit_go && !restart_q && !ovf_q && d_v_q;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			restart_q   <= 1'b0;
			bu_q        <= '0;
			chk_v_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CLRW'(1);
			end
			if (state_q == ST_IDLE && op_valid) begin
				restart_q <= action == ACT_RESTART;
				if (action == ACT_RESTART) begin
					clr_q <= '0;
					bu_q  <= '0;
				end
			end
			if (state_q == ST_EARLY) begin
				chk_v_s1 <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				if (chk_v_s1 && hit) begin
					chk_v_s1 <= 1'b0;
				end else begin
					chk_v_s1 <= more;
				end
			end
			if (state_q == ST_COMMIT && commit_go) begin
				res_valid_q <= 1'b1;
				restart_q   <= 1'b0;
				if (!restart_q && !ovf_q) begin
					bu_q <= bu_next;
				end
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				eng_q <= eng_c;
				d_v_q <= d_ok;
				a_v_q <= a_ok;
				b_v_q <= b_ok;
				d_q   <= SW'(dest_slot[SLOT_FIELD_W-2:0]);
				a_q   <= SW'(src_a_slot[SLOT_FIELD_W-2:0]);
				b_q   <= SW'(src_b_slot[SLOT_FIELD_W-2:0]);
			end
			ST_RD_B: begin
				a_w_q  <= a_v_q && lw_rdata[BW];
				a_wb_q <= lw_rdata[BW-1:0];
			end
			ST_RD_D: begin
				b_w_q  <= b_v_q && lw_rdata[BW];
				b_wb_q <= lw_rdata[BW-1:0];
			end
			ST_EARLY: begin
				d_w_q      <= d_v_q && lw_rdata[BW];
				d_wb_q     <= lw_rdata[BW-1:0];
				earliest_q <= (ea > eb) ? ea : eb;
				scan_q     <= (ea > eb) ? ea : eb;
			end
			ST_SCAN: begin
				if (chk_v_s1 && hit) begin
					place_q <= chk_nb_s1;
					row_q   <= row_inc;
					ovf_q   <= 1'b0;
				end else if (more) begin
					chk_nb_s1 <= scan_q;
					scan_q    <= scan_q + CW'(1);
				end else if (!chk_v_s1) begin
					// no room in an open bundle: open one at the end
					place_q <= new_place;
					row_q   <= row_new;
					ovf_q   <= 32'(new_place) >= MAX_BUNDLES;
				end
			end
			ST_COMMIT: begin
				if (commit_go) begin
					if (restart_q) begin
						res_bundle_q <= '0;
						res_count_q  <= '0;
						res_ovf_q    <= 1'b0;
					end else if (ovf_q) begin
						res_bundle_q <= '0;
						res_count_q  <= bu_q;
						res_ovf_q    <= 1'b1;
					end else begin
						res_bundle_q <= place_q[BW-1:0];
						res_count_q  <= bu_next;
						res_ovf_q    <= 1'b0;
					end
				end
			end
			ST_CLEAR, ST_RD_A: begin
			end
		endcase
	end

	assign res_valid    = res_valid_q;
	assign bundle       = BUNDLE_W'(res_bundle_q);
	assign bundle_count = COUNT_W'(res_count_q);
	assign overflow     = res_ovf_q;

	a_bu_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(bu_q) <= MAX_BUNDLES)
		else $error("bundles used past capacity");

	a_clear_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> op_stall)
		else $error("word accepted during clearing pass");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && chk_v_s1) |-> (chk_nb_s1 < bu_q && chk_nb_s1 >= earliest_q))
		else $error("scan checks a bundle outside the open range");

	a_place_earliest: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT && !restart_q && !ovf_q) |-> place_q >= earliest_q)
		else $error("operation placed before its sources are written");

endmodule

@@ rtl/core/vliw_bundle_list_scheduler.sv @@
// ----------------------------------------------------------------------------
// vliw_bundle_list_scheduler
// schedule: reads the last writers of both sources and the destination, scans
//   the open bundles from the earliest allowed one through the single read port
//   of the usage ram, opens a new bundle when none fits; one word in flight
// restart: clears both rams, max(SLOT_COUNT, MAX_BUNDLES) words (default 4096)
// reset: the same clearing pass runs first, op_stall stays high until it ends
// ----------------------------------------------------------------------------
module vliw_bundle_list_scheduler #(
	parameter int unsigned SLOT_COUNT   = vbls_pkg::DEF_SLOT_COUNT,
	parameter int unsigned MAX_BUNDLES  = vbls_pkg::DEF_MAX_BUNDLES,
	parameter int unsigned ENGINE_COUNT = vbls_pkg::DEF_ENGINE_COUNT
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     psel,
	input  logic                                     penable,
	input  logic                                     pwrite,
	input  logic [vbls_pkg::PADDR_W-1:0]             paddr,
	input  logic [vbls_pkg::PDATA_W-1:0]             pwdata,
	output logic [vbls_pkg::PDATA_W-1:0]             prdata,
	output logic                                     pready,
	input  logic                                     op_valid,
	output logic                                     op_stall,
	input  logic                                     action,
	input  logic [vbls_pkg::ENGINE_FIELD_W-1:0]      engine,
	input  logic signed [vbls_pkg::SLOT_FIELD_W-1:0] dest_slot,
	input  logic signed [vbls_pkg::SLOT_FIELD_W-1:0] src_a_slot,
	input  logic signed [vbls_pkg::SLOT_FIELD_W-1:0] src_b_slot,
	output logic                                     res_valid,
	input  logic                                     res_stall,
	output logic [vbls_pkg::BUNDLE_W-1:0]            bundle,
	output logic [vbls_pkg::COUNT_W-1:0]             bundle_count,
	output logic                                     overflow
);
	import vbls_pkg::*;

	localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int unsigned BW = (MAX_BUNDLES > 1) ? $clog2(MAX_BUNDLES) : 1;
	localparam int unsigned RW = ENGINE_COUNT * LIMIT_W;

	logic [ENGINE_COUNT-1:0][LIMIT_W-1:0] limits;

	logic          lw_we;
	logic [SW-1:0] lw_waddr, lw_raddr;
	logic [BW:0]   lw_wdata, lw_rdata;
	logic          use_we;
	logic [BW-1:0] use_waddr, use_raddr;
	logic [RW-1:0] use_wdata, use_rdata;

	vbls_cfg #(
		.ENGINE_COUNT(ENGINE_COUNT)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.limits  (limits)
	);

	// last writer per slot: valid bit and bundle index
	vbls_ram #(
		.DEPTH(SLOT_COUNT),
		.WIDTH(BW + 1)
	) u_lw_ram (
		.clk   (clk),
		.we    (lw_we),
		.waddr (lw_waddr),
		.wdata (lw_wdata),
		.raddr (lw_raddr),
		.rdata (lw_rdata)
	);

	// issue slots used per bundle, one 4-bit lane per engine
	vbls_ram #(
		.DEPTH(MAX_BUNDLES),
		.WIDTH(RW)
	) u_use_ram (
		.clk   (clk),
		.we    (use_we),
		.waddr (use_waddr),
		.wdata (use_wdata),
		.raddr (use_raddr),
		.rdata (use_rdata)
	);

	vbls_ctrl #(
		.SLOT_COUNT   (SLOT_COUNT),
		.MAX_BUNDLES  (MAX_BUNDLES),
		.ENGINE_COUNT (ENGINE_COUNT)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_valid     (op_valid),
		.op_stall     (op_stall),
		.action       (action),
		.engine       (engine),
		.dest_slot    (dest_slot),
		.src_a_slot   (src_a_slot),
		.src_b_slot   (src_b_slot),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.bundle       (bundle),
		.bundle_count (bundle_count),
		.overflow     (overflow),
		.limits       (limits),
		.lw_we        (lw_we),
		.lw_waddr     (lw_waddr),
		.lw_wdata     (lw_wdata),
		.lw_raddr     (lw_raddr),
		.lw_rdata     (lw_rdata),
		.use_we       (use_we),
		.use_waddr    (use_waddr),
		.use_wdata    (use_wdata),
		.use_raddr    (use_raddr),
		.use_rdata    (use_rdata)
	);

endmodule

@@ verif/bundle_placement_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bundle_placement_checker
// follows the register writes and the operation channel, works out the bundle,
// count and overflow of each operation and checks each returned word in order
// ----------------------------------------------------------------------------
module bundle_placement_checker
	import vbls_pkg::*;
(
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic                            pready,
	input  logic [PADDR_W-1:0]              paddr,
	input  logic [PDATA_W-1:0]              pwdata,
	input  logic                            op_valid,
	input  logic                            op_stall,
	input  logic                            action,
	input  logic [ENGINE_FIELD_W-1:0]       engine,
	input  logic signed [SLOT_FIELD_W-1:0]  dest_slot,
	input  logic signed [SLOT_FIELD_W-1:0]  src_a_slot,
	input  logic signed [SLOT_FIELD_W-1:0]  src_b_slot,
	input  logic                            res_valid,
	input  logic                            res_stall,
	input  logic [BUNDLE_W-1:0]             bundle,
	input  logic [COUNT_W-1:0]              bundle_count,
	input  logic                            overflow,
	output int                              errors,
	output int                              pending
);

	localparam int SLOTS   = DEF_SLOT_COUNT;
	localparam int BUNDLES = DEF_MAX_BUNDLES;
	localparam int ENGINES = DEF_ENGINE_COUNT;

	typedef struct packed {
		logic [BUNDLE_W-1:0] bundle;
		logic [COUNT_W-1:0]  count;
		logic                ovf;
	} placement_t;

	logic [LIMIT_W-1:0] limit_of [MAX_ENGINES];
	int                 writer_bundle [SLOTS];
	bit                 written [SLOTS];
	byte unsigned       issued [BUNDLES][ENGINES];
	int                 open_bundles;
	int                 fails;
	placement_t         placements_due [$];

	assign errors = fails;

	function automatic int slot_index(logic signed [SLOT_FIELD_W-1:0] raw);
		if (raw < 0 || raw >= SLOTS)
			return -1;
		return int'(raw);
	endfunction

	function automatic bit clash(int s, int nb);
		return s >= 0 && written[s] && writer_bundle[s] == nb;
	endfunction

	task automatic clear_tables();
		for (int s = 0; s < SLOTS; s++) begin
			writer_bundle[s] = 0;
			written[s] = 0;
		end
		for (int nb = 0; nb < BUNDLES; nb++)
			for (int e = 0; e < ENGINES; e++)
				issued[nb][e] = 0;
		open_bundles = 0;
	endtask

	task automatic place_op(input logic act, input logic [ENGINE_FIELD_W-1:0] eng_raw,
		input logic signed [SLOT_FIELD_W-1:0] d_raw,
		input logic signed [SLOT_FIELD_W-1:0] a_raw,
		input logic signed [SLOT_FIELD_W-1:0] b_raw);
		int eng, lim, earliest, spot, d, a, b;
		bit placed;
		placement_t p;
		p = '0;
		if (act == ACT_RESTART) begin
			clear_tables();
			placements_due.push_back(p);
			return;
		end
		eng = (eng_raw >= ENGINES) ? ENGINES - 1 : int'(eng_raw);
		lim = int'(limit_of[eng]);
		d = slot_index(d_raw);
		a = slot_index(a_raw);
		b = slot_index(b_raw);
		earliest = 0;
		placed = 0;
		spot = 0;
		if (a >= 0 && written[a])
			earliest = writer_bundle[a] + 1;
		if (b >= 0 && written[b] && writer_bundle[b] + 1 > earliest)
			earliest = writer_bundle[b] + 1;
		// first open bundle with a free issue slot and no hazard on any slot
		for (int nb = earliest; nb < open_bundles && nb < BUNDLES && !placed; nb++) begin
			if (issued[nb][eng] < lim && !clash(d, nb) && !clash(a, nb) && !clash(b, nb)) begin
				spot = nb;
				placed = 1;
			end
		end
		if (placed)
			issued[spot][eng]++;
		else begin
			spot = (open_bundles > earliest) ? open_bundles : earliest;
			if (spot >= BUNDLES) begin
				// nothing placed, tables untouched
				p.count = COUNT_W'(open_bundles);
				p.ovf = 1'b1;
				placements_due.push_back(p);
				return;
			end
			issued[spot][eng] = 1;
		end
		if (spot >= open_bundles)
			open_bundles = spot + 1;
		if (d >= 0) begin
			writer_bundle[d] = spot;
			written[d] = 1;
		end
		p.bundle = BUNDLE_W'(spot);
		p.count = COUNT_W'(open_bundles);
		placements_due.push_back(p);
	endtask

	always @(posedge clk or negedge arst_n) begin
		placement_t want;
		if (!arst_n) begin
			for (int e = 0; e < MAX_ENGINES; e++)
				limit_of[e] = RESET_LIMITS[e];
			clear_tables();
			placements_due.delete();
			fails = 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] < CFG_COUNT)
				limit_of[paddr[PADDR_W-1:2]] = pwdata[LIMIT_W-1:0];
			if (res_valid && !res_stall) begin
				if (placements_due.size() == 0) begin
					if (fails < 10)
						$display("unexpected word: bundle %0d bundle_count %0d overflow %0d",
							bundle, bundle_count, overflow);
					fails++;
				end else begin
					want = placements_due.pop_front();
					if (bundle !== want.bundle || bundle_count !== want.count ||
						overflow !== want.ovf) begin
						if (fails < 10)
							$display({"mismatch: bundle %0d (exp %0d) ",
								"bundle_count %0d (exp %0d) overflow %0d (exp %0d)"},
								bundle, want.bundle, bundle_count, want.count,
								overflow, want.ovf);
						fails++;
					end
				end
			end
			if (op_valid && !op_stall)
				place_op(action, engine, dest_slot, src_a_slot, src_b_slot);
			pending <= placements_due.size();
		end
	end

endmodule

@@ verif/tb_vliw_bundle_list_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vliw_bundle_list_scheduler
// drives operations and register writes into the scheduler with random gaps
// and stalls on both channels; a directed opening, random phases under several
// slot limits and a short dependency chain through one slot
// ----------------------------------------------------------------------------
module tb_vliw_bundle_list_scheduler;
	import vbls_pkg::*;

	localparam logic signed [SLOT_FIELD_W-1:0] NO_SLOT    = '1;
	localparam logic signed [SLOT_FIELD_W-1:0] CHAIN_SLOT = 7;
	localparam int                             PHASE_OPS  = 170;
	localparam int                             CHAIN_OPS  = 50;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic op_valid = 1'b0;
	logic op_stall;
	logic action = ACT_SCHEDULE;
	logic [ENGINE_FIELD_W-1:0] engine = '0;
	logic signed [SLOT_FIELD_W-1:0] dest_slot = '0;
	logic signed [SLOT_FIELD_W-1:0] src_a_slot = '0;
	logic signed [SLOT_FIELD_W-1:0] src_b_slot = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [BUNDLE_W-1:0] bundle;
	logic [COUNT_W-1:0] bundle_count;
	logic overflow;

	int errors;
	int pending;
	bit no_idle = 0;
	bit hold_req = 0;

	always #5ns clk = ~clk;

	vliw_bundle_list_scheduler i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.op_valid     (op_valid),
		.op_stall     (op_stall),
		.action       (action),
		.engine       (engine),
		.dest_slot    (dest_slot),
		.src_a_slot   (src_a_slot),
		.src_b_slot   (src_b_slot),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.bundle       (bundle),
		.bundle_count (bundle_count),
		.overflow     (overflow)
	);

	bundle_placement_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.op_valid     (op_valid),
		.op_stall     (op_stall),
		.action       (action),
		.engine       (engine),
		.dest_slot    (dest_slot),
		.src_a_slot   (src_a_slot),
		.src_b_slot   (src_b_slot),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.bundle       (bundle),
		.bundle_count (bundle_count),
		.overflow     (overflow),
		.errors       (errors),
		.pending      (pending)
	);

	task automatic send_op(input logic act, input logic [ENGINE_FIELD_W-1:0] eng,
		input logic signed [SLOT_FIELD_W-1:0] d,
		input logic signed [SLOT_FIELD_W-1:0] a,
		input logic signed [SLOT_FIELD_W-1:0] b);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			op_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op_valid <= 1'b1;
		action <= act;
		engine <= eng;
		dest_slot <= d;
		src_a_slot <= a;
		src_b_slot <= b;
		@(posedge clk);
		while (op_stall) @(posedge clk);
	endtask

	function automatic logic signed [SLOT_FIELD_W-1:0] pick_slot();
		int r;
		logic signed [SLOT_FIELD_W-1:0] s;
		r = $urandom_range(0, 99);
		// a small pool keeps dependencies and write conflicts frequent
		if (r < 55)
			s = SLOT_FIELD_W'($urandom_range(0, 11));
		else if (r < 75)
			s = NO_SLOT;
		else if (r < 88)
			s = SLOT_FIELD_W'($urandom_range(0, 1023));
		else if (r < 95)
			s = SLOT_FIELD_W'($urandom_range(1024, 2047));
		else
			s = 1023;
		return s;
	endfunction

	task automatic random_op();
		logic [ENGINE_FIELD_W-1:0] eng;
		if ($urandom_range(0, 99) < 3) begin
			eng = ENGINE_FIELD_W'($urandom_range(0, 7));
			send_op(ACT_RESTART, eng, pick_slot(), pick_slot(), pick_slot());
		end else begin
			eng = ($urandom_range(0, 99) < 90) ? ENGINE_FIELD_W'($urandom_range(0, 4))
				: ENGINE_FIELD_W'($urandom_range(5, 7));
			send_op(ACT_SCHEDULE, eng, pick_slot(), pick_slot(), pick_slot());
		end
	endtask

	task automatic write_reg(input int idx, input logic [LIMIT_W-1:0] val);
		logic [PDATA_W-1:0] word;
		word = $urandom();
		word[LIMIT_W-1:0] = val;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(idx * 4);
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		op_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// result side: random stall per word, one long hold-off on request
	initial begin : result_sink
		int n;
		forever begin
			if (hold_req) begin
				n = 400;
				hold_req = 0;
			end else if (no_idle)
				n = 0;
			else
				n = $urandom_range(0, 9);
			if (n > 0) begin
				res_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
		end
	end

	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		logic [LIMIT_W-1:0] lim;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// clearing pass after reset
		@(posedge clk);
		while (op_stall) @(posedge clk);

		// directed opening under the reset limits
		send_op(ACT_RESTART, 7, 1023, 1023, 1023);
		send_op(ACT_SCHEDULE, 0, 0, NO_SLOT, NO_SLOT);
		send_op(ACT_SCHEDULE, 0, 0, NO_SLOT, NO_SLOT);
		send_op(ACT_SCHEDULE, 0, 1023, 0, NO_SLOT);
		send_op(ACT_SCHEDULE, 4, NO_SLOT, NO_SLOT, NO_SLOT);
		send_op(ACT_SCHEDULE, 4, NO_SLOT, NO_SLOT, NO_SLOT);
		send_op(ACT_SCHEDULE, 5, NO_SLOT, NO_SLOT, NO_SLOT);
		send_op(ACT_SCHEDULE, 6, NO_SLOT, NO_SLOT, NO_SLOT);
		send_op(ACT_SCHEDULE, 7, NO_SLOT, NO_SLOT, NO_SLOT);
		send_op(ACT_SCHEDULE, 2, 3, NO_SLOT, NO_SLOT);
		send_op(ACT_SCHEDULE, 2, 4, NO_SLOT, NO_SLOT);
		send_op(ACT_SCHEDULE, 2, 5, NO_SLOT, NO_SLOT);
		send_op(ACT_SCHEDULE, 3, NO_SLOT, 1023, 1023);
		send_op(ACT_SCHEDULE, 1, 5, 1023, 0);
		send_op(ACT_SCHEDULE, 3, -1024, -2, -1024);
		send_op(ACT_SCHEDULE, 1, 512, 5, 3);
		send_op(ACT_SCHEDULE, 0, 1023, 512, 1023);
		send_op(ACT_SCHEDULE, 4, 0, 4, 512);
		send_op(ACT_RESTART, 0, 0, 0, 0);
		send_op(ACT_SCHEDULE, 1, 0, 0, 1023);
		send_op(ACT_SCHEDULE, 1, 1, 0, NO_SLOT);
		wait_drained();

		// random phases: minimum limits, maximum limits, random, zero limit
		for (int ph = 0; ph < 6; ph++) begin
			for (int e = 0; e < CFG_COUNT; e++) begin
				if (ph == 0)
					lim = 1;
				else if (ph == 1)
					lim = 15;
				else if (ph == 5 && e == 2)
					lim = 0;
				else
					lim = LIMIT_W'($urandom_range(1, 15));
				write_reg(e, lim);
			end
			if (ph == 5)
				// addresses past the register file must be ignored
				for (int e = CFG_COUNT; e < 8; e++)
					write_reg(e, LIMIT_W'($urandom_range(0, 15)));
			no_idle = (ph == 2);
			for (int i = 0; i < PHASE_OPS; i++) begin
				if (ph == 3 && i == 20)
					hold_req = 1;
				random_op();
			end
			no_idle = 0;
			wait_drained();
		end

		// dependency chain through one slot
		send_op(ACT_RESTART, 0, NO_SLOT, NO_SLOT, NO_SLOT);
		for (int i = 0; i < CHAIN_OPS; i++)
			send_op(ACT_SCHEDULE, ENGINE_FIELD_W'($urandom_range(0, 4)), CHAIN_SLOT,
				CHAIN_SLOT,
				$urandom_range(0, 1) ? NO_SLOT : SLOT_FIELD_W'($urandom_range(16, 1023)));
		send_op(ACT_SCHEDULE, 0, NO_SLOT, NO_SLOT, NO_SLOT);
		send_op(ACT_SCHEDULE, 1, 3, CHAIN_SLOT, NO_SLOT);
		send_op(ACT_SCHEDULE, 4, 1023, NO_SLOT, NO_SLOT);
		send_op(ACT_SCHEDULE, 7, NO_SLOT, NO_SLOT, CHAIN_SLOT);
		send_op(ACT_RESTART, 3, NO_SLOT, NO_SLOT, NO_SLOT);
		send_op(ACT_SCHEDULE, 2, CHAIN_SLOT, CHAIN_SLOT, NO_SLOT);
		wait_drained();

		repeat (64) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
